[hdl/software_timer_slot_table_macros.svh]
// assertion helpers for the timer slot table
`ifndef SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH
`define SOFTWARE_TIMER_SLOT_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SWTMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SWTMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/swtmr_pkg.sv]
package swtmr_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OPC_W      = 2;
  localparam int INTERVAL_W = 31;
  localparam int ID_W       = 5;
  localparam int OWNER_W    = 4;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 3;

  localparam int IN_FIELDS_W = INTERVAL_W + 1 + ID_W + OWNER_W + TIME_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ID_W + 7) / 8) * 8;

  // bit offsets inside in_tdata
  localparam int IN_INTERVAL_LO = 0;
  localparam int IN_REPEAT_LO   = IN_INTERVAL_LO + INTERVAL_W;
  localparam int IN_ID_LO       = IN_REPEAT_LO + 1;
  localparam int IN_OWNER_LO    = IN_ID_LO + ID_W;
  localparam int IN_NOW_LO      = IN_OWNER_LO + OWNER_W;

  typedef enum logic [OPC_W-1:0] {
    OPC_SET    = 2'd0,
    OPC_KILL   = 2'd1,
    OPC_TICK   = 2'd2,
    OPC_UNUSED = 2'd3
  } opcode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_OK   = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_KILL_OK  = 3'd2,
    KIND_KILL_BAD = 3'd3,
    KIND_FIRED    = 3'd4,
    KIND_DONE     = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SET  = 5'b00010,
    ST_KILL = 5'b00100,
    ST_TICK = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

endpackage

[hdl/software_timer_slot_table.sv]
// software timer slot table
// input channel (in_*): one transaction per command; in_tuser holds the opcode
//   (set, kill, tick), in_tdata the timer fields. accepted only while idle.
// output channel (out_*): result transactions; out_tuser is the result kind,
//   out_tdata the timer id, out_tlast marks the final result of a command.
// set: the slot walk checks one slot per cycle for the lowest free one
//   and answers full when every slot is taken.
// kill: the id is checked in the kill state, and the result goes to the output register from there.
// tick: one slot per cycle, unless a fired result is held by the receiver,
//   through the shared elapsed-time subtract and compare unit, then a done result.
// the table takes no new command until the last one is through; the walk
//   counter and the single slot-store read port set the pace of each walk.
// a single output register holds each result; when the receiver stalls the
//   walk pauses on the slot whose result cannot yet be placed.
// reset clears all active bits and the control state; the slot stores are
//   only read for active slots, so they need no clearing pass.
`include "software_timer_slot_table_macros.svh"

module software_timer_slot_table (
  input  logic                              clk,
  input  logic                              rst_n,
  // command channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // interval_ms[30:0], repeat_mode[31], timer_id[36:32], owner_tag[40:37],
  // now_ms[72:41], zero fill above
  input  logic [swtmr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // opcode
  input  logic [swtmr_pkg::OPC_W-1:0]       in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // result_id[4:0], zero fill above
  output logic [swtmr_pkg::OUT_TDATA_W-1:0] out_tdata,
  // result_kind
  output logic [swtmr_pkg::KIND_W-1:0]      out_tuser,
  // last_result
  output logic                              out_tlast
);

  localparam int SW = swtmr_pkg::SLOT_W;

  // control
  swtmr_pkg::state_t state_r, state_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic [swtmr_pkg::NUM_SLOTS-1:0] active_r, active_nxt;

  // latched command fields
  logic [swtmr_pkg::INTERVAL_W-1:0] interval_r;
  logic                             repeat_r;
  logic [swtmr_pkg::ID_W-1:0]       tid_r;
  logic [swtmr_pkg::OWNER_W-1:0]    owner_r;
  logic [swtmr_pkg::TIME_W-1:0]     now_r;

  // slot stores
  logic [swtmr_pkg::OWNER_W-1:0]    mem_owner  [swtmr_pkg::NUM_SLOTS];
  logic [swtmr_pkg::TIME_W-1:0]     mem_start  [swtmr_pkg::NUM_SLOTS];
  logic [swtmr_pkg::INTERVAL_W-1:0] mem_period [swtmr_pkg::NUM_SLOTS];
  logic                             mem_repeat [swtmr_pkg::NUM_SLOTS];

  logic [SW-1:0]                    rd_addr;
  logic [swtmr_pkg::OWNER_W-1:0]    rd_owner_r;
  logic [swtmr_pkg::TIME_W-1:0]     rd_start_r;
  logic [swtmr_pkg::INTERVAL_W-1:0] rd_period_r;
  logic                             rd_repeat_r;

  logic set_wr, start_wr;
  logic [swtmr_pkg::TIME_W-1:0] start_wdata;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  swtmr_pkg::kind_t            out_kind_r, out_kind_nxt;
  logic [swtmr_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_acc;
  logic                        out_free;
  logic                        emit;
  logic                        idx_last;
  logic [swtmr_pkg::ID_W-1:0]  idx_id;
  logic [SW-1:0]               kill_idx;
  logic                        kill_ok;
  logic [swtmr_pkg::TIME_W-1:0] elapsed;
  logic                        fire;
  logic                        advance;

  assign in_tready = (state_r == swtmr_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign idx_last  = (idx_r == SW'(swtmr_pkg::NUM_SLOTS - 1));
  assign idx_id    = swtmr_pkg::ID_W'({1'b0, idx_r} + {{SW{1'b0}}, 1'b1});

  // kill id check: nonzero, in range, and active
  assign kill_idx = SW'(tid_r - swtmr_pkg::ID_W'(1));
  assign kill_ok  = (tid_r != '0) &&
                    ({{(32 - swtmr_pkg::ID_W){1'b0}}, tid_r} <= 32'(swtmr_pkg::NUM_SLOTS)) &&
                    active_r[kill_idx];

  // shared elapsed-time unit: wrapping subtract and compare against period
  assign elapsed = now_r - rd_start_r;
  assign fire    = active_r[idx_r] && (rd_owner_r == owner_r) &&
                   (elapsed >= {1'b0, rd_period_r});
  assign advance = !fire || out_free;
  assign start_wdata = (state_r == swtmr_pkg::ST_SET) ? now_r
                                                       : rd_start_r + {1'b0, rd_period_r};

  // read address leads the tick walk by one slot, so the registered read data matches idx_r
  always_comb begin
    rd_addr = idx_r;
    if (state_r == swtmr_pkg::ST_IDLE) begin
      rd_addr = '0;
    end else if (state_r == swtmr_pkg::ST_TICK && advance) begin
      rd_addr = idx_r + SW'(1);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    emit          = 1'b0;
    set_wr        = 1'b0;
    start_wr      = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      swtmr_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (in_acc) begin
          case (swtmr_pkg::opcode_t'(in_tuser))
            swtmr_pkg::OPC_SET:  state_nxt = swtmr_pkg::ST_SET;
            swtmr_pkg::OPC_KILL: state_nxt = swtmr_pkg::ST_KILL;
            swtmr_pkg::OPC_TICK: state_nxt = swtmr_pkg::ST_TICK;
            default:             state_nxt = swtmr_pkg::ST_IDLE;
          endcase
        end
      end
      swtmr_pkg::ST_SET: begin
        if (!active_r[idx_r]) begin
          if (out_free) begin
            emit              = 1'b1;
            set_wr            = 1'b1;
            start_wr          = 1'b1;
            active_nxt[idx_r] = 1'b1;
            out_kind_nxt      = swtmr_pkg::KIND_SET_OK;
            out_id_nxt        = idx_id;
            out_last_nxt      = 1'b1;
            state_nxt         = swtmr_pkg::ST_IDLE;
          end
        end else if (idx_last) begin
          if (out_free) begin
            emit         = 1'b1;
            out_kind_nxt = swtmr_pkg::KIND_FULL;
            out_id_nxt   = '0;
            out_last_nxt = 1'b1;
            state_nxt    = swtmr_pkg::ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      swtmr_pkg::ST_KILL: begin
        if (out_free) begin
          emit         = 1'b1;
          out_last_nxt = 1'b1;
          state_nxt    = swtmr_pkg::ST_IDLE;
          if (kill_ok) begin
            active_nxt[kill_idx] = 1'b0;
            out_kind_nxt         = swtmr_pkg::KIND_KILL_OK;
            out_id_nxt           = tid_r;
          end else begin
            out_kind_nxt = swtmr_pkg::KIND_KILL_BAD;
            out_id_nxt   = '0;
          end
        end
      end
      swtmr_pkg::ST_TICK: begin
        if (advance) begin
          if (fire) begin
            emit         = 1'b1;
            out_kind_nxt = swtmr_pkg::KIND_FIRED;
            out_id_nxt   = idx_id;
            out_last_nxt = 1'b0;
            if (rd_repeat_r) begin
              start_wr = 1'b1;
            end else begin
              active_nxt[idx_r] = 1'b0;
            end
          end
          if (idx_last) begin
            state_nxt = swtmr_pkg::ST_DONE;
          end else begin
            idx_nxt = idx_r + SW'(1);
          end
        end
      end
      swtmr_pkg::ST_DONE: begin
        if (out_free) begin
          emit         = 1'b1;
          out_kind_nxt = swtmr_pkg::KIND_DONE;
          out_id_nxt   = '0;
          out_last_nxt = 1'b1;
          state_nxt    = swtmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swtmr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swtmr_pkg::ST_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
    if (in_acc) begin
      interval_r <= in_tdata[swtmr_pkg::IN_INTERVAL_LO +: swtmr_pkg::INTERVAL_W];
      repeat_r   <= in_tdata[swtmr_pkg::IN_REPEAT_LO];
      tid_r      <= in_tdata[swtmr_pkg::IN_ID_LO +: swtmr_pkg::ID_W];
      owner_r    <= in_tdata[swtmr_pkg::IN_OWNER_LO +: swtmr_pkg::OWNER_W];
      now_r      <= in_tdata[swtmr_pkg::IN_NOW_LO +: swtmr_pkg::TIME_W];
    end
  end

  // slot store writes
  always_ff @(posedge clk) begin
    if (set_wr) begin
      mem_owner[idx_r]  <= owner_r;
      mem_period[idx_r] <= interval_r;
      mem_repeat[idx_r] <= repeat_r;
    end
    if (start_wr) begin
      mem_start[idx_r] <= start_wdata;
    end
  end

  // slot store registered read
  always_ff @(posedge clk) begin
    rd_owner_r  <= mem_owner[rd_addr];
    rd_start_r  <= mem_start[rd_addr];
    rd_period_r <= mem_period[rd_addr];
    rd_repeat_r <= mem_repeat[rd_addr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(swtmr_pkg::OUT_TDATA_W - swtmr_pkg::ID_W){1'b0}}, out_id_r};

  // checks
  `SWTMR_ASSERT_NOW(a_id_nonzero, out_tvalid && (out_tuser == swtmr_pkg::KIND_SET_OK || out_tuser == swtmr_pkg::KIND_FIRED || out_tuser == swtmr_pkg::KIND_KILL_OK), out_tdata != '0, "result id is zero for a timer result")
  `SWTMR_ASSERT_NOW(a_last_flag, out_tvalid && out_tuser != swtmr_pkg::KIND_FIRED, out_tlast, "final result lacks tlast")
  `SWTMR_ASSERT_NEXT(a_set_marks, emit && state_r == swtmr_pkg::ST_SET && out_kind_nxt == swtmr_pkg::KIND_SET_OK, active_r[$past(idx_r)], "set did not mark its slot active")
  `SWTMR_ASSERT_NEXT(a_walk_step, state_r == swtmr_pkg::ST_TICK && advance && !idx_last, idx_r == $past(idx_r) + SW'(1), "tick walk skipped a slot")

endmodule

[verif/software_timer_slot_table_tb.sv]
module software_timer_slot_table_tb;
  import swtmr_pkg::*;

  // watchdog limit; a correct run needs a small fraction of this
  localparam int unsigned MAX_CYCLES      = 1_000_000;
  // long receiver hold-off so the single output register backs up into the input
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // quiet time after the last result
  localparam int unsigned SETTLE_CYCLES   = 3 * (NUM_SLOTS + 2);
  // owner shared by every timer of the full-table burst
  localparam logic [OWNER_W-1:0] BURST_OWNER = 4'd5;

  // one result transaction as the table should produce it
  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   id;
    logic              last;
  } timer_event_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // interval_ms, repeat_mode, timer_id, owner_tag, now_ms, zero fill above
  logic [IN_TDATA_W-1:0]  in_tdata;
  // opcode
  logic [OPC_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  // result_id, zero fill above
  logic [OUT_TDATA_W-1:0] out_tdata;
  // result_kind
  logic [KIND_W-1:0]      out_tuser;
  logic                   out_tlast;

  // shadow copy of the slot table, updated as each command transaction is accepted
  logic                   tmr_live     [NUM_SLOTS];
  logic [OWNER_W-1:0]     tmr_owner    [NUM_SLOTS];
  logic [TIME_W-1:0]      tmr_start    [NUM_SLOTS];
  logic [INTERVAL_W-1:0]  tmr_period   [NUM_SLOTS];
  logic                   tmr_periodic [NUM_SLOTS];

  // results still owed by the table, oldest first
  timer_event_t expected_events[$];

  // sender and receiver pacing controls
  bit offering     = 1'b0;
  bit tx_no_gaps   = 1'b0;
  bit rx_no_gaps   = 1'b0;
  bit hold_off_req = 1'b0;

  // bookkeeping for the end of run
  int unsigned cycle_count  = 0;
  int unsigned mismatches   = 0;
  int unsigned n_results    = 0;
  int unsigned n_fired      = 0;
  int unsigned n_full       = 0;
  int unsigned widest_burst = 0;
  int unsigned op_count [4] = '{0, 0, 0, 0};

  software_timer_slot_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 40);
  endfunction

  // owners cluster on a few tags so ticks find work, the rest spans all tags
  function automatic logic [OWNER_W-1:0] random_owner();
    if ($urandom_range(0, 3) != 0) return OWNER_W'($urandom_range(0, 2));
    else return OWNER_W'($urandom_range(0, 15));
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  // queues one owed result transaction
  function automatic void owe(kind_t kind, logic [ID_W-1:0] id, logic last);
    timer_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.last = last;
    expected_events.push_back(ev);
  endfunction

  // works out the results of one accepted command and updates the shadow table
  function automatic void predict_timer_table(opcode_t op, logic [INTERVAL_W-1:0] interval,
      logic rep, logic [ID_W-1:0] tid, logic [OWNER_W-1:0] owner, logic [TIME_W-1:0] now);
    int free_slot;
    int unsigned burst;
    logic [TIME_W-1:0] elapsed;
    free_slot = -1;
    burst = 0;
    op_count[op]++;
    case (op)
      OPC_SET: begin
        // lowest free slot wins
        for (int i = 0; i < NUM_SLOTS; i++)
          if (!tmr_live[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          owe(KIND_FULL, '0, 1'b1);
          n_full++;
        end else begin
          tmr_live[free_slot]     = 1'b1;
          tmr_owner[free_slot]    = owner;
          tmr_start[free_slot]    = now;
          tmr_period[free_slot]   = interval;
          tmr_periodic[free_slot] = rep;
          owe(KIND_SET_OK, ID_W'(free_slot + 1), 1'b1);
        end
      end
      OPC_KILL: begin
        // id zero, ids past the table and idle slots are all refused
        if (tid == 0 || tid > NUM_SLOTS || !tmr_live[tid - 1]) begin
          owe(KIND_KILL_BAD, '0, 1'b1);
        end else begin
          tmr_live[tid - 1] = 1'b0;
          owe(KIND_KILL_OK, tid, 1'b1);
        end
      end
      OPC_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (tmr_live[i] && tmr_owner[i] == owner) begin
            // elapsed time wraps modulo 2^32
            elapsed = now - tmr_start[i];
            if (elapsed >= TIME_W'(tmr_period[i])) begin
              owe(KIND_FIRED, ID_W'(i + 1), 1'b0);
              burst++;
              if (tmr_periodic[i]) tmr_start[i] = tmr_start[i] + TIME_W'(tmr_period[i]);
              else tmr_live[i] = 1'b0;
            end
          end
        end
        owe(KIND_DONE, '0, 1'b1);
        n_fired += burst;
        if (burst > widest_burst) widest_burst = burst;
      end
      default: begin
        // unused opcode leaves the table alone and answers nothing
      end
    endcase
  endfunction

  // offers one command transaction, returns at the edge where it was taken
  task automatic send_command(opcode_t op, logic [INTERVAL_W-1:0] interval, logic rep,
      logic [ID_W-1:0] tid, logic [OWNER_W-1:0] owner, logic [TIME_W-1:0] now);
    int unsigned gap;
    logic [IN_TDATA_W-1:0] word;
    gap = tx_no_gaps ? 0 : pick_gap();
    // valid is low while not offering, so hold it low through a gap before raising it
    if (!offering && gap == 0) gap = 1;
    if (gap != 0) begin
      if (offering) in_tvalid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    word = '0;
    word[IN_INTERVAL_LO +: INTERVAL_W] = interval;
    word[IN_REPEAT_LO]                 = rep;
    word[IN_ID_LO +: ID_W]             = tid;
    word[IN_OWNER_LO +: OWNER_W]       = owner;
    word[IN_NOW_LO +: TIME_W]          = now;
    in_tdata  <= word;
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    offering   = 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_timer_table(op, interval, rep, tid, owner, now);
  endtask

  // fields a command does not use carry random junk
  task automatic issue_set(logic [INTERVAL_W-1:0] interval, logic rep,
      logic [OWNER_W-1:0] owner, logic [TIME_W-1:0] now);
    send_command(OPC_SET, interval, rep, ID_W'($urandom), owner, now);
  endtask

  task automatic issue_kill(logic [ID_W-1:0] tid);
    send_command(OPC_KILL, INTERVAL_W'($urandom), 1'($urandom_range(0, 1)), tid,
                 OWNER_W'($urandom), $urandom);
  endtask

  task automatic issue_tick(logic [OWNER_W-1:0] owner, logic [TIME_W-1:0] now);
    send_command(OPC_TICK, INTERVAL_W'($urandom), 1'($urandom_range(0, 1)),
                 ID_W'($urandom), owner, now);
  endtask

  // sender stops offering until every owed result has come back
  task automatic wait_drained();
    if (offering) in_tvalid <= 1'b0;
    offering = 1'b0;
    do @(posedge clk); while (expected_events.size() != 0);
  endtask

  // frees every live timer so a test starts from an empty table
  task automatic clear_all_timers();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (tmr_live[i]) issue_kill(ID_W'(i + 1));
  endtask

  // field extremes, every opcode, refused kills, zero period, wrapping time
  task automatic test_edge_cases();
    issue_tick(4'd0, 32'd0);                                   // empty table, done only
    issue_kill(5'd0);                                          // id zero
    issue_kill(5'd16);                                         // idle slot
    issue_kill(5'd17);                                         // just past the table
    issue_kill(5'd31);                                         // all id bits set
    send_command(OPC_UNUSED, '1, 1'b1, '1, '1, '1);            // ignored, no result
    issue_set(31'd0, 1'b0, 4'd15, 32'hFFFF_FFFF);              // zero-period one-shot
    issue_set(31'h7FFF_FFFF, 1'b1, 4'd0, 32'd0);               // longest period
    issue_set(31'd10, 1'b1, 4'd15, 32'hFFFF_FFF0);             // periodic across the wrap
    issue_set(31'd5, 1'b0, 4'd1, 32'd100);
    issue_tick(4'd15, 32'hFFFF_FFFF);                          // zero period and elapsed 15
    issue_tick(4'd0, 32'h7FFF_FFFE);                           // one short of due
    issue_tick(4'd0, 32'h7FFF_FFFF);                           // exactly due
    issue_tick(4'd1, 32'd104);
    issue_tick(4'd1, 32'd105);                                 // one-shot fires and frees
    issue_kill(5'd4);                                          // already freed
    issue_kill(5'd2);
    issue_kill(5'd2);                                          // second kill refused
    issue_set(31'd3, 1'b0, 4'd7, 32'd0);                       // reuses the lowest free slot
    issue_tick(4'd15, 32'd4);                                  // time has wrapped past zero
    issue_tick(4'd7, 32'd3);
  endtask

  // fill every slot under one owner while the receiver holds off, then a full
  // answer and a tick where all sixteen timers fire
  task automatic test_full_table_backpressure();
    logic [TIME_W-1:0] base_ms;
    clear_all_timers();
    base_ms    = $urandom();
    tx_no_gaps = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < NUM_SLOTS; i++)
      issue_set(31'd0, 1'($urandom_range(0, 1)), BURST_OWNER, base_ms + i);
    issue_set(INTERVAL_W'($urandom), 1'b1, BURST_OWNER, base_ms);
    issue_tick(BURST_OWNER, base_ms);
    issue_tick(BURST_OWNER, base_ms + 1);
    tx_no_gaps = 1'b0;
    wait_drained();
    clear_all_timers();
  endtask

  // well-formed traffic with random content on a moving clock, plus noise;
  // middle segment runs both sides flat out, last one pauses to drain now and then
  task automatic test_random_traffic();
    logic [TIME_W-1:0]     clock_ms;
    logic [INTERVAL_W-1:0] period;
    logic [ID_W-1:0]       tid;
    int unsigned           taken;
    int unsigned           pick;
    int unsigned           r;
    int                    live_ids[$];
    clock_ms = $urandom();
    for (int seg = 0; seg < 3; seg++) begin
      tx_no_gaps = (seg == 1);
      rx_no_gaps = (seg == 1);
      taken = 0;
      while (taken < 60) begin
        // time mostly creeps forward, sometimes jumps anywhere
        if ($urandom_range(0, 15) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(0, 25);
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_command(OPC_UNUSED, INTERVAL_W'($urandom), 1'($urandom_range(0, 1)),
                       ID_W'($urandom), OWNER_W'($urandom), $urandom);
          continue;
        end else if (pick < 40) begin
          r = $urandom_range(0, 9);
          if (r < 6) period = INTERVAL_W'($urandom_range(0, 40));
          else if (r < 9) period = INTERVAL_W'($urandom_range(0, 300));
          else period = INTERVAL_W'($urandom);
          issue_set(period, 1'($urandom_range(0, 1)), random_owner(), clock_ms);
        end else if (pick < 65) begin
          live_ids.delete();
          for (int i = 0; i < NUM_SLOTS; i++)
            if (tmr_live[i]) live_ids.push_back(i + 1);
          if (live_ids.size() != 0 && $urandom_range(0, 9) < 7)
            tid = ID_W'(live_ids[$urandom_range(0, live_ids.size() - 1)]);
          else
            tid = ID_W'($urandom_range(0, 31));
          issue_kill(tid);
        end else begin
          issue_tick(random_owner(), clock_ms);
        end
        taken++;
        if (seg == 2 && taken % 20 == 0) wait_drained();
      end
    end
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  // receiver: random ready with short and long stalls, or a long counted hold-off
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_OFF_CYCLES;
      end else if (stall_left == 0 && !rx_no_gaps && $urandom_range(0, 2) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compares each accepted result transaction with the oldest owed one
  initial begin : result_checker
    timer_event_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        n_results++;
        if (expected_events.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0d id %0d last %0b",
                                  out_tuser, out_tdata, out_tlast));
        end else begin
          want = expected_events.pop_front();
          if (out_tuser !== want.kind)
            note_mismatch($sformatf("result_kind expected %0d got %0d", want.kind, out_tuser));
          if (out_tdata !== OUT_TDATA_W'(want.id))
            note_mismatch($sformatf("result_id expected %0d got %0d", want.id, out_tdata));
          if (out_tlast !== want.last)
            note_mismatch($sformatf("last_result expected %0b got %0b", want.last, out_tlast));
        end
      end
    end
  end

  // watchdog
  initial begin : cycle_limit
    while (cycle_count <= MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles with %0d results owed", cycle_count,
             expected_events.size());
    $display("software_timer_slot_table_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OPC_SET;
    for (int i = 0; i < NUM_SLOTS; i++) tmr_live[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_cases();
    test_full_table_backpressure();
    test_random_traffic();

    // let the last results out, then watch for stray ones
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_events.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", expected_events.size()));

    $display("run covered %0d set, %0d kill, %0d tick and %0d unused-opcode transactions",
             op_count[OPC_SET], op_count[OPC_KILL], op_count[OPC_TICK], op_count[OPC_UNUSED]);
    $display("%0d results checked: %0d fired, %0d table full, widest tick burst %0d",
             n_results, n_fired, n_full, widest_burst);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("software_timer_slot_table_tb OK");
    end else begin
      $display("software_timer_slot_table_tb NOT OK");
    end
    $finish;
  end

endmodule
